/* design/fpr_pkg.sv */
// shared request and result types for the fermat primality round unit
package fpr_pkg;

  localparam int CAND_W = 32;
  localparam int RAND_W = 31;

  typedef struct packed {
    logic [CAND_W-1:0] candidate;
    logic [RAND_W-1:0] random_word;
  } in_t;

  typedef struct packed {
    logic              verdict;
    logic [CAND_W-1:0] power_value;
    logic [CAND_W-1:0] witness;
  } out_t;

endpackage

/* design/fpr_modmul.sv */
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module fpr_modmul #(
  parameter int NUM_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] op_a,
  input  logic [NUM_BITS-1:0] op_b,
  input  logic [NUM_BITS-1:0] modulus,
  output logic                done,
  output logic [NUM_BITS-1:0] product
);
  import fpr_pkg::*;

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] a_r, a_nxt;
  logic [NUM_BITS-1:0] b_r, b_nxt;
  logic [NUM_BITS-1:0] n_r, n_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;

  logic [NUM_BITS+1:0] sum;
  logic [NUM_BITS+1:0] one_n;
  logic [NUM_BITS+1:0] two_n;
  logic [NUM_BITS+1:0] red;

  // acc < n and a < n, so 2*acc + a < 3n: at most two subtractions of n
  always_comb begin
    one_n = {2'b00, n_r};
    two_n = {1'b0, n_r, 1'b0};
    sum   = {1'b0, acc_r, 1'b0} + (b_r[NUM_BITS-1] ? {2'b00, a_r} : '0);
    if (sum >= two_n) begin
      red = sum - two_n;
    end else if (sum >= one_n) begin
      red = sum - one_n;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    n_nxt    = n_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = op_a;
      b_nxt   = op_b;
      n_nxt   = modulus;
      acc_nxt = '0;
      cnt_nxt = CNT_W'(NUM_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = red[NUM_BITS-1:0];
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      acc_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    n_r <= n_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("modmul done held for more than one cycle");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !run_r)
    else $error("modmul done while still running");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> run_r && !done)
    else $error("modmul did not begin after start");

endmodule

/* design/fermat_primality_round_unit.sv */
// fermat trial unit: serial witness reduction then serial square-and-multiply
// candidates decided at once (n <= 3 or even) are answered in the cycle after start;
// otherwise 31 division steps, then NUM_BITS exponent bits; each bit costs a
// squaring, plus a multiply on a set bit,
// in the single bit-serial modular multiplier
// one request at a time, next one taken as the result strobes; sync reset to idle
module fermat_primality_round_unit #(
  parameter int NUM_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  fpr_pkg::in_t  in_data,
  output logic          out_valid,
  output fpr_pkg::out_t out_data
);
  import fpr_pkg::*;

  localparam int MAX_STEPS = (NUM_BITS > RAND_W) ? NUM_BITS : RAND_W;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_PREP = 5'b00100,
    S_MUL  = 5'b01000,
    S_SQR  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0] n_r, n_nxt;
  logic [NUM_BITS-1:0] d_r, d_nxt;
  logic [RAND_W-1:0]   rw_r, rw_nxt;
  logic [NUM_BITS-1:0] rem_r, rem_nxt;
  logic [NUM_BITS-1:0] exp_r, exp_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [NUM_BITS-1:0] sq_r, sq_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic [NUM_BITS-1:0] n_in;
  logic [NUM_BITS:0]   trial;
  logic [NUM_BITS-1:0] rem_step;
  logic                mm_start;
  logic [NUM_BITS-1:0] mm_a;
  logic                mm_done;
  logic [NUM_BITS-1:0] mm_prod;

  assign n_in = in_data.candidate[NUM_BITS-1:0];

  // restoring division step: remainder of the random word by n - 3
  always_comb begin
    trial = {rem_r, rw_r[RAND_W-1]};
    if (trial >= {1'b0, d_r}) begin
      rem_step = NUM_BITS'(trial - {1'b0, d_r});
    end else begin
      rem_step = trial[NUM_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    rw_nxt        = rw_r;
    rem_nxt       = rem_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mm_start      = 1'b0;
    mm_a          = sq_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt  = n_in;
          d_nxt  = n_in - NUM_BITS'(3);
          rw_nxt = in_data.random_word;
          out_data_nxt.power_value = '0;
          out_data_nxt.witness     = '0;
          if (n_in <= NUM_BITS'(1)) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.verdict = 1'b0;
          end else if (n_in == NUM_BITS'(2) || n_in == NUM_BITS'(3)) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.verdict = 1'b1;
          end else if (!n_in[0]) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.verdict = 1'b0;
          end else begin
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(RAND_W);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = rem_step;
        rw_nxt  = rw_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          // witness = 2 + remainder, always below n
          sq_nxt    = rem_step + NUM_BITS'(2);
          acc_nxt   = NUM_BITS'(1);
          exp_nxt   = n_r - NUM_BITS'(1);
          cnt_nxt   = CNT_W'(NUM_BITS);
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        mm_start = 1'b1;
        if (exp_r[0]) begin
          mm_a      = acc_r;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_done) begin
          acc_nxt   = mm_prod;
          mm_start  = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          sq_nxt  = mm_prod;
          exp_nxt = exp_r >> 1;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.verdict     = (acc_r == NUM_BITS'(1));
            out_data_nxt.power_value = CAND_W'(acc_r);
            out_data_nxt.witness     = CAND_W'(rem_r + NUM_BITS'(2));
            state_nxt                = S_IDLE;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  fpr_modmul #(
    .NUM_BITS (NUM_BITS)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (sq_r),
    .modulus (n_r),
    .done    (mm_done),
    .product (mm_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    rw_r       <= rw_nxt;
    rem_r      <= rem_nxt;
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_req_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("request neither answered nor in progress");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.witness == '0 |-> out_data.power_value == '0)
    else $error("decided-at-once result carries a power value");

  a_verdict_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.witness != '0 |->
      out_data.verdict == (out_data.power_value == CAND_W'(1)))
    else $error("verdict disagrees with power value");

  a_mm_only_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> state_r == S_MUL || state_r == S_SQR)
    else $error("multiplier finished outside the exponent loop");

endmodule
